// ===== rtl/core/ffsa_pkg.sv =====
// Package for the first-fit segment allocator: constants, types and codes.
`default_nettype none
package ffsa_pkg;

    // Sizing of the managed region and of the segment table.
    localparam int REGION_BYTES = 16384;
    localparam int HEADER_BYTES = 24;
    localparam int MIN_ALLOC    = 8;
    localparam int MAX_SEGMENTS = 512;

    // Field widths of the transactions.
    localparam int REQ_W  = 15;
    localparam int OFF_W  = 14;
    localparam int STAT_W = 3;

    // Internal widths.
    localparam int SEG_W  = $clog2(REGION_BYTES + 1);
    localparam int POS_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int NEED_W = REQ_W + 2;

    // Command codes.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_ALLOCATED    = 3'd0,
        ST_NO_FIT       = 3'd1,
        ST_BAD_SIZE     = 3'd2,
        ST_FREED        = 3'd3,
        ST_FREE_IGNORED = 3'd4
    } t_status;

    typedef struct packed {
        logic             command;
        logic [REQ_W-1:0] request_size;
        logic [OFF_W-1:0] free_offset;
    } t_in_item;

    typedef struct packed {
        t_status          status;
        logic [OFF_W-1:0] payload_offset;
    } t_out_item;

    // One table entry: segment size with header, and its free mark.
    typedef struct packed {
        logic [SEG_W-1:0] size;
        logic             free;
    } t_seg;

    typedef logic [POS_W-1:0] t_pos;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_ROTATE,
        CM_APPLY
    } t_cell_mode;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_RIGHT,
        SH_LEFT1,
        SH_LEFT2
    } t_shift;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        t_cell_mode mode;
        logic       wa_en;
        t_pos       wa_idx;
        t_seg       wa_ent;
        logic       wb_en;
        t_seg       wb_ent;
        t_shift     sh;
        t_pos       sh_from;
    } t_cell_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/core/ffsa_cell.sv =====
// One cell of the segment chain: holds a single table entry.
`default_nettype none
module ffsa_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ffsa_pkg::t_pos     i_index,
    input  ffsa_pkg::t_seg     i_init,
    input  ffsa_pkg::t_cell_cmd i_cmd,
    input  ffsa_pkg::t_seg     i_left,
    input  ffsa_pkg::t_seg     i_right,
    input  ffsa_pkg::t_seg     i_right2,
    output ffsa_pkg::t_seg     o_seg
);
    import ffsa_pkg::*;

    t_seg r_seg;
    t_seg n_seg;

    // Select the next entry from the broadcast command and this cell's place.
    always_comb begin
        n_seg = r_seg;
        case (i_cmd.mode)
            CM_ROTATE: begin
                n_seg = i_right;
            end
            CM_APPLY: begin
                if (i_cmd.wa_en && i_index == i_cmd.wa_idx) begin
                    n_seg = i_cmd.wa_ent;
                end else if (i_cmd.wb_en && i_index == i_cmd.wa_idx + POS_W'(1)) begin
                    n_seg = i_cmd.wb_ent;
                end else if (i_index >= i_cmd.sh_from) begin
                    case (i_cmd.sh)
                        SH_RIGHT: n_seg = i_left;
                        SH_LEFT1: n_seg = i_right;
                        SH_LEFT2: n_seg = i_right2;
                        default:  n_seg = r_seg;
                    endcase
                end
            end
            default: n_seg = r_seg;
        endcase
    end

    // Entry register; reset loads the initial table.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg <= i_init;
        end else begin
            r_seg <= n_seg;
        end
    end

    assign o_seg = r_seg;

endmodule
`default_nettype wire

// ===== rtl/core/first_fit_segment_allocator_unit.sv =====
// Top level of the first-fit segment allocator: controller and chain of cells.
//
//   Channel | Valid        | Stall        | Payload
//   --------+--------------+--------------+---------------------------
//   input   | i_in_valid   | o_in_stall   | i_in  (t_in_item)
//   result  | o_out_valid  | i_out_stall  | o_out (t_out_item)
//
// For each item the table rotates once through the chain past cell 0,
// where the search runs, then the apply step performs the split, mark or
// merge on all cells at once. An allocate of size zero skips the
// rotation and goes straight to the apply step. Reset loads one free
// segment covering the region. A stalled result holds the apply step, and
// a new input transaction is taken whenever the controller is idle.
`default_nettype none
module first_fit_segment_allocator_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ffsa_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ffsa_pkg::t_out_item o_out
);
    import ffsa_pkg::*;

    t_state    r_state;
    t_state    n_state;
    t_in_item  r_cmd;
    logic      r_bad;
    t_pos      r_t;
    logic [SEG_W-1:0]  r_start;
    logic [NEED_W-1:0] r_need;
    logic      r_found;
    t_pos      r_m;
    logic [SEG_W-1:0]  r_mstart;
    logic [SEG_W-1:0]  r_msize;
    logic      r_mfree;
    logic      r_pfree;
    logic [SEG_W-1:0]  r_psize;
    logic      r_sfree;
    logic [SEG_W-1:0]  r_ssize;
    logic      r_look_next;
    t_seg      r_prev;
    t_pos      r_count;
    t_pos      n_count;
    t_out_item r_out;
    logic      r_out_valid;

    t_cell_cmd cell_cmd;
    t_out_item result;
    t_seg      segs [MAX_SEGMENTS];
    t_seg      head;
    logic      accept;
    logic      fire;
    logic      head_valid;
    logic      hit;
    logic      split;
    logic [NEED_W-1:0] need_in;

    assign head   = segs[0];
    assign accept = i_in_valid && !o_in_stall;
    assign fire   = (r_state == S_APPLY) && (!r_out_valid || !i_out_stall);
    assign head_valid = r_t < r_count;
    assign need_in = NEED_W'(((32'(i_in.request_size) + MIN_ALLOC - 1) / MIN_ALLOC)
                             * MIN_ALLOC + HEADER_BYTES);

    // Row of cells; each sees its neighbors around the ring.
    for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
        localparam int LEFT   = (k + MAX_SEGMENTS - 1) % MAX_SEGMENTS;
        localparam int RIGHT  = (k + 1) % MAX_SEGMENTS;
        localparam int RIGHT2 = (k + 2) % MAX_SEGMENTS;
        t_seg init;
        assign init.size = (k == 0) ? SEG_W'(REGION_BYTES) : '0;
        assign init.free = (k == 0);
        ffsa_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_index  (POS_W'(k)),
            .i_init   (init),
            .i_cmd    (cell_cmd),
            .i_left   (segs[LEFT]),
            .i_right  (segs[RIGHT]),
            .i_right2 (segs[RIGHT2]),
            .o_seg    (segs[k])
        );
    end

    // Match test on the entry currently at the head of the chain.
    always_comb begin
        if (r_cmd.command == CMD_ALLOC) begin
            hit = head_valid && !r_found && head.free && (NEED_W'(head.size) >= r_need);
        end else begin
            hit = head_valid && !r_found
                  && (NEED_W'(r_start) + NEED_W'(HEADER_BYTES) == NEED_W'(r_cmd.free_offset));
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in.command == CMD_ALLOC && i_in.request_size == '0) begin
                        n_state = S_APPLY;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_t == POS_W'(MAX_SEGMENTS - 1)) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (fire) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the controller: cell command, result and count update.
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        split = (NEED_W'(r_msize) >= r_need + NEED_W'(HEADER_BYTES + MIN_ALLOC))
                && (r_count < POS_W'(MAX_SEGMENTS));
        cell_cmd = '0;
        cell_cmd.mode = CM_HOLD;
        cell_cmd.sh = SH_NONE;
        result.status = ST_NO_FIT;
        result.payload_offset = '0;
        n_count = r_count;
        if (r_state == S_SCAN) begin
            cell_cmd.mode = CM_ROTATE;
        end
        if (r_cmd.command == CMD_ALLOC) begin
            if (r_bad) begin
                result.status = ST_BAD_SIZE;
            end else if (r_found) begin
                result.status = ST_ALLOCATED;
                result.payload_offset = OFF_W'(r_mstart + SEG_W'(HEADER_BYTES));
                cell_cmd.wa_en = 1'b1;
                cell_cmd.wa_idx = r_m;
                cell_cmd.wa_ent.free = 1'b0;
                if (split) begin
                    cell_cmd.wa_ent.size = SEG_W'(r_need);
                    cell_cmd.wb_en = 1'b1;
                    cell_cmd.wb_ent.size = r_msize - SEG_W'(r_need);
                    cell_cmd.wb_ent.free = 1'b1;
                    cell_cmd.sh = SH_RIGHT;
                    cell_cmd.sh_from = r_m + POS_W'(2);
                    n_count = r_count + POS_W'(1);
                end else begin
                    cell_cmd.wa_ent.size = r_msize;
                end
            end
        end else begin
            result.status = ST_FREE_IGNORED;
            if (r_found && !r_mfree) begin
                result.status = ST_FREED;
                cell_cmd.wa_en = 1'b1;
                cell_cmd.wa_ent.free = 1'b1;
                if (r_pfree && r_sfree) begin
                    cell_cmd.wa_idx = r_m - POS_W'(1);
                    cell_cmd.wa_ent.size = r_psize + r_msize + r_ssize;
                    cell_cmd.sh = SH_LEFT2;
                    cell_cmd.sh_from = r_m;
                    n_count = r_count - POS_W'(2);
                end else if (r_pfree) begin
                    cell_cmd.wa_idx = r_m - POS_W'(1);
                    cell_cmd.wa_ent.size = r_psize + r_msize;
                    cell_cmd.sh = SH_LEFT1;
                    cell_cmd.sh_from = r_m;
                    n_count = r_count - POS_W'(1);
                end else if (r_sfree) begin
                    cell_cmd.wa_idx = r_m;
                    cell_cmd.wa_ent.size = r_msize + r_ssize;
                    cell_cmd.sh = SH_LEFT1;
                    cell_cmd.sh_from = r_m + POS_W'(1);
                    n_count = r_count - POS_W'(1);
                end else begin
                    cell_cmd.wa_idx = r_m;
                    cell_cmd.wa_ent.size = r_msize;
                end
            end
        end
        if (r_state == S_APPLY) begin
            cell_cmd.mode = fire ? CM_APPLY : CM_HOLD;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= POS_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Search bookkeeping as the table streams past cell 0.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd       <= i_in;
            r_bad       <= (i_in.command == CMD_ALLOC) && (i_in.request_size == '0);
            r_need      <= need_in;
            r_t         <= '0;
            r_start     <= '0;
            r_found     <= 1'b0;
            r_look_next <= 1'b0;
            r_prev      <= '0;
        end else if (r_state == S_SCAN) begin
            r_t    <= r_t + POS_W'(1);
            r_prev <= head;
            if (head_valid) begin
                r_start <= r_start + head.size;
            end
            if (hit) begin
                r_found     <= 1'b1;
                r_m         <= r_t;
                r_mstart    <= r_start;
                r_msize     <= head.size;
                r_mfree     <= head.free;
                r_pfree     <= (r_t != '0) && r_prev.free;
                r_psize     <= r_prev.size;
                r_sfree     <= 1'b0;
                r_look_next <= 1'b1;
            end else if (r_look_next) begin
                r_look_next <= 1'b0;
                r_sfree     <= head_valid && head.free;
                r_ssize     <= head.size;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire
